### hw/rtl/cvrs_pkg.sv
`timescale 1ns / 1ps

package cvrs_pkg;

    localparam int READ_INDEX_BITS_DEF = 16;
    localparam int REF_POS_BITS_DEF    = 32;

    localparam int OP_KIND_BITS    = 3;
    localparam int OP_LENGTH_BITS  = 28;
    localparam int POS_FIELD_BITS  = 31;
    localparam int ALLELE_LEN_BITS = 10;
    localparam int READ_LEN_BITS   = 16;
    localparam int RES_BITS        = 16;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [OP_KIND_BITS-1:0] OP_MATCH     = 3'd0;
    localparam logic [OP_KIND_BITS-1:0] OP_DELETION  = 3'd1;
    localparam logic [OP_KIND_BITS-1:0] OP_REF_SKIP  = 3'd2;
    localparam logic [OP_KIND_BITS-1:0] OP_INSERTION = 3'd3;
    localparam logic [OP_KIND_BITS-1:0] OP_SOFT_CLIP = 3'd4;

    typedef struct packed {
        logic first_op;
        logic last_op;
    } op_flags_t;

    typedef struct packed {
        logic not_empty;
        logic not_full;
    } queue_status_t;

    // queue entry: flags, read cursor, read length, usable match bases,
    // reference cursor, site start, site end
    function automatic int entry_bits(int read_bits, int pos_bits);
        return $bits(op_flags_t) + 3 * read_bits + (pos_bits + 2) + 2 * (pos_bits + 3);
    endfunction

endpackage

### hw/rtl/cvrs_intf.sv
`timescale 1ns / 1ps

interface cvrs_op_if import cvrs_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [OP_KIND_BITS-1:0]    op_kind;
    logic [OP_LENGTH_BITS-1:0]  op_length;
    logic                       first_op;
    logic                       last_op;
    logic [POS_FIELD_BITS-1:0]  align_start;
    logic [POS_FIELD_BITS-1:0]  variant_pos;
    logic [ALLELE_LEN_BITS-1:0] ref_allele_len;
    logic [READ_LEN_BITS-1:0]   read_length;

    modport source (
        output valid, op_kind, op_length, first_op, last_op,
               align_start, variant_pos, ref_allele_len, read_length,
        input  ready
    );

    modport sink (
        input  valid, op_kind, op_length, first_op, last_op,
               align_start, variant_pos, ref_allele_len, read_length,
        output ready
    );
endinterface

interface cvrs_res_if import cvrs_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [RES_BITS-1:0] pre_length;
    logic [RES_BITS-1:0] variant_length;
    logic [RES_BITS-1:0] post_start;
    logic                post_present;
    logic                site_aligned;

    modport source (
        output valid, pre_length, variant_length, post_start, post_present,
               site_aligned,
        input  ready
    );

    modport sink (
        input  valid, pre_length, variant_length, post_start, post_present,
               site_aligned,
        output ready
    );
endinterface

### hw/rtl/cvrs_front.sv
`timescale 1ns / 1ps

module cvrs_front import cvrs_pkg::*; #(
    parameter int READ_INDEX_BITS = READ_INDEX_BITS_DEF,
    parameter int REF_POS_BITS    = REF_POS_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    cvrs_op_if.sink       op,
    input  queue_status_t q_status,
    output logic          push,
    output logic [entry_bits(READ_INDEX_BITS, REF_POS_BITS)-1:0] push_data
);

    localparam int RB  = READ_INDEX_BITS;
    localparam int PB  = REF_POS_BITS;
    localparam int RCW = RB + 1;
    localparam int PCW = PB + 2;
    localparam int SW  = PB + 3;
    localparam int RSW = ((RCW > OP_LENGTH_BITS) ? RCW : OP_LENGTH_BITS) + 1;
    localparam int PSW = ((PCW > OP_LENGTH_BITS) ? PCW : OP_LENGTH_BITS) + 1;
    localparam int LCW = (RB > OP_LENGTH_BITS) ? RB : OP_LENGTH_BITS;

    logic [PCW-1:0] ref_cur_reg,  ref_cur_next;
    logic [RCW-1:0] read_cur_reg, read_cur_next;
    logic [SW-1:0]  site_start_reg;
    logic [SW-1:0]  site_end_reg;
    logic [RB-1:0]  read_bases_reg;

    logic           accept;
    logic [PCW-1:0] ref_eff;
    logic [RCW-1:0] read_eff;
    logic [SW-1:0]  vp_ext;
    logic [SW-1:0]  ss_eff;
    logic [SW-1:0]  se_eff;
    logic [RB-1:0]  rb_eff;
    logic [RB-1:0]  avail;
    logic           len_short;
    logic [RB-1:0]  n_val;
    logic [RSW-1:0] rsum;
    logic [PSW-1:0] psum;
    logic [RCW-1:0] read_adv;
    logic [PCW-1:0] ref_adv;
    op_flags_t      flags;

    assign op.ready = q_status.not_full;
    assign accept   = op.valid && op.ready;

    always_comb
    begin
        // a first op restarts the walk from the read-level fields
        ref_eff  = op.first_op ? PCW'(PB'(op.align_start)) : ref_cur_reg;
        read_eff = op.first_op ? '0 : read_cur_reg;
        vp_ext   = SW'(PB'(op.variant_pos));
        ss_eff   = op.first_op ? (vp_ext - SW'(1)) : site_start_reg;
        se_eff   = op.first_op ? (vp_ext + SW'(op.ref_allele_len) - SW'(1)) : site_end_reg;
        rb_eff   = op.first_op ? RB'(op.read_length) : read_bases_reg;

        // match bases that still fall inside the read
        avail     = rb_eff - read_eff[RB-1:0];
        len_short = LCW'(op.op_length) < LCW'(avail);
        if (op.op_kind == OP_MATCH && read_eff < RCW'(rb_eff))
        begin
            n_val = len_short ? RB'(op.op_length) : avail;
        end
        else
        begin
            n_val = '0;
        end

        rsum     = RSW'(read_eff) + RSW'(op.op_length);
        psum     = PSW'(ref_eff) + PSW'(op.op_length);
        read_adv = (|rsum[RSW-1:RCW]) ? '1 : rsum[RCW-1:0];
        ref_adv  = (|psum[PSW-1:PCW]) ? '1 : psum[PCW-1:0];

        unique case (op.op_kind)
            OP_MATCH:
            begin
                ref_cur_next  = ref_adv;
                read_cur_next = read_adv;
            end
            OP_DELETION, OP_REF_SKIP:
            begin
                ref_cur_next  = ref_adv;
                read_cur_next = read_eff;
            end
            OP_INSERTION, OP_SOFT_CLIP:
            begin
                ref_cur_next  = ref_eff;
                read_cur_next = read_adv;
            end
            default:
            begin
                ref_cur_next  = ref_eff;
                read_cur_next = read_eff;
            end
        endcase

        flags.first_op = op.first_op;
        flags.last_op  = op.last_op;
    end

    assign push      = accept;
    assign push_data = {flags, read_eff[RB-1:0], rb_eff, n_val, ref_eff, ss_eff, se_eff};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_cur_reg    <= '0;
            read_cur_reg   <= '0;
            site_start_reg <= '0;
            site_end_reg   <= '0;
            read_bases_reg <= '0;
        end
        else if (accept)
        begin
            ref_cur_reg    <= ref_cur_next;
            read_cur_reg   <= read_cur_next;
            site_start_reg <= ss_eff;
            site_end_reg   <= se_eff;
            read_bases_reg <= rb_eff;
        end
    end

endmodule

### hw/rtl/cvrs_queue.sv
`timescale 1ns / 1ps

module cvrs_queue import cvrs_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output queue_status_t    status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg,  count_next;

    always_comb
    begin
        wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        unique case ({push, pop})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    assign status.not_empty = (count_reg != '0);
    assign status.not_full  = (count_reg != CW'(DEPTH));
    assign pop_data         = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            count_reg <= count_next;
        end
    end

endmodule

### hw/rtl/cvrs_back.sv
`timescale 1ns / 1ps

module cvrs_back import cvrs_pkg::*; #(
    parameter int READ_INDEX_BITS = READ_INDEX_BITS_DEF,
    parameter int REF_POS_BITS    = REF_POS_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  queue_status_t q_status,
    input  logic [entry_bits(READ_INDEX_BITS, REF_POS_BITS)-1:0] pop_data,
    output logic          pop,
    cvrs_res_if.source    res
);

    localparam int RB  = READ_INDEX_BITS;
    localparam int PCW = REF_POS_BITS + 2;
    localparam int SW  = REF_POS_BITS + 3;

    op_flags_t      e_flags;
    logic [RB-1:0]  e_r;
    logic [RB-1:0]  e_rb;
    logic [RB-1:0]  e_n;
    logic [PCW-1:0] e_p;
    logic [SW-1:0]  e_ss;
    logic [SW-1:0]  e_se;

    logic           en;
    logic [SW-1:0]  p_ext;
    logic [SW-1:0]  d_start;
    logic [SW-1:0]  d_end;
    logic           ds_pos;
    logic           de_pos;
    logic [RB-1:0]  k_val;
    logic [RB-1:0]  j0_val;
    logic           upd_b;
    logic           upd_a;

    logic           b1_valid_reg;
    op_flags_t      b1_flags_reg;
    logic [RB-1:0]  b1_r_reg;
    logic [RB-1:0]  b1_rb_reg;
    logic [RB-1:0]  b1_k_reg;
    logic [RB-1:0]  b1_j0_reg;
    logic           b1_upd_b_reg;
    logic           b1_upd_a_reg;

    logic [RB-1:0]  before_reg, before_next;
    logic           found_reg,  found_next;
    logic [RB-1:0]  after_reg,  after_next;
    logic [RB-1:0]  before_in;
    logic           found_in;

    logic           res_valid_reg;
    logic [RB-1:0]  res_pre_reg;
    logic           res_found_reg;
    logic [RB-1:0]  res_after_reg;
    logic [RB-1:0]  res_rb_reg;
    logic [RB-1:0]  stop;
    logic [RB-1:0]  var_len;

    assign {e_flags, e_r, e_rb, e_n, e_p, e_ss, e_se} = pop_data;

    // freeze the whole back end while a result waits on the receiver
    assign en  = !res_valid_reg || res.ready;
    assign pop = en && q_status.not_empty;

    // offsets of the site edges from this op's reference cursor
    always_comb
    begin
        p_ext   = SW'(e_p);
        d_start = e_ss - p_ext;
        d_end   = e_se - p_ext;
        ds_pos  = !d_start[SW-1] && (d_start != '0);
        de_pos  = !d_end[SW-1] && (d_end != '0);
        k_val   = (d_start > SW'(e_n)) ? e_n : d_start[RB-1:0];
        upd_b   = ds_pos && (e_n != '0);
        j0_val  = de_pos ? d_end[RB-1:0] : '0;
        upd_a   = de_pos ? (d_end < SW'(e_n)) : (e_n != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b1_valid_reg <= q_status.not_empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_flags_reg <= e_flags;
            b1_r_reg     <= e_r;
            b1_rb_reg    <= e_rb;
            b1_k_reg     <= k_val;
            b1_j0_reg    <= j0_val;
            b1_upd_b_reg <= upd_b;
            b1_upd_a_reg <= upd_a;
        end
    end

    always_comb
    begin
        before_in   = b1_flags_reg.first_op ? '0 : before_reg;
        found_in    = b1_flags_reg.first_op ? 1'b0 : found_reg;
        before_next = b1_upd_b_reg ? (b1_r_reg + b1_k_reg) : before_in;
        found_next  = found_in || b1_upd_a_reg;
        // keep the first base found at or past the site end
        after_next  = (!found_in && b1_upd_a_reg) ? (b1_r_reg + b1_j0_reg) : after_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            before_reg    <= '0;
            found_reg     <= 1'b0;
            after_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            if (b1_valid_reg)
            begin
                before_reg <= before_next;
                found_reg  <= found_next;
                after_reg  <= after_next;
            end
            res_valid_reg <= b1_valid_reg && b1_flags_reg.last_op;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_pre_reg   <= before_next;
            res_found_reg <= found_next;
            res_after_reg <= after_next;
            res_rb_reg    <= b1_rb_reg;
        end
    end

    always_comb
    begin
        stop    = res_found_reg ? res_after_reg : res_rb_reg;
        var_len = (stop > res_pre_reg) ? (stop - res_pre_reg) : '0;
    end

    assign res.valid          = res_valid_reg;
    assign res.pre_length     = RES_BITS'(res_pre_reg);
    assign res.variant_length = RES_BITS'(var_len);
    assign res.post_start     = res_found_reg ? RES_BITS'(res_after_reg) : '0;
    assign res.post_present   = res_found_reg;
    assign res.site_aligned   = (var_len != '0) && ((res_pre_reg != '0) || res_found_reg);

endmodule

### hw/rtl/cigar_variant_read_splitter.sv
`timescale 1ns / 1ps
// CIGAR walk that splits one aligned read around a variant site.
// op (sink): one CIGAR operation per transaction. The first op of a read
//   carries first_op and the read-level fields (start, variant position,
//   reference allele length, read length); the final op carries last_op.
// res (source): one transaction per op marked last_op, giving pre length,
//   variant length, post start, post present and aligned-at-variant.
// Throughput: one op per cycle while op.ready is high, with no gaps
//   between reads. A last_op is written into the 4-entry op queue, then
//   passes the offset stage register and the result register, which raises
//   res.valid.
// The front end advances the cursors once per accepted op; the back end
//   resolves the site edges one op per cycle while res is not stalled.
// When res is stalled the result register and the back end hold; the front
//   keeps accepting until the op queue holds 4 ops, then drops op.ready.
// Reset clears the cursors, the site and the read length to zero; ops that
//   arrive before any first_op walk from that state.
module cigar_variant_read_splitter import cvrs_pkg::*; #(
    parameter int READ_INDEX_BITS = READ_INDEX_BITS_DEF,
    parameter int REF_POS_BITS    = REF_POS_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    cvrs_op_if.sink    op,
    cvrs_res_if.source res
);

    localparam int EW = entry_bits(READ_INDEX_BITS, REF_POS_BITS);

    queue_status_t   q_status;
    logic            push;
    logic [EW-1:0]   push_data;
    logic            pop;
    logic [EW-1:0]   pop_data;

    cvrs_front #(
        .READ_INDEX_BITS (READ_INDEX_BITS),
        .REF_POS_BITS    (REF_POS_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    cvrs_queue #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    cvrs_back #(
        .READ_INDEX_BITS (READ_INDEX_BITS),
        .REF_POS_BITS    (REF_POS_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .pop_data (pop_data),
        .pop      (pop),
        .res      (res)
    );

endmodule

### hw/rtl/cvrs_checker.sv
`timescale 1ns / 1ps

module cvrs_port_props import cvrs_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                op_valid,
    input logic                op_ready,
    input logic                op_last_op,
    input logic                res_valid,
    input logic                res_ready,
    input logic [RES_BITS-1:0] pre_length,
    input logic [RES_BITS-1:0] variant_length,
    input logic [RES_BITS-1:0] post_start,
    input logic                post_present,
    input logic                site_aligned
);

    logic seen_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_last_reg <= 1'b0;
        end
        else if (op_valid && op_ready && op_last_op)
        begin
            seen_last_reg <= 1'b1;
        end
    end

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result valid dropped before its transaction");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(pre_length) && $stable(variant_length)
            && $stable(post_start) && $stable(post_present)
            && $stable(site_aligned))
        else $error("result payload changed while stalled");

    a_res_needs_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> seen_last_reg)
        else $error("result shown with no last op accepted");

    a_full_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !op_ready |-> $past(res_valid && !res_ready))
        else $error("op queue filled without a result stall");

endmodule

bind cigar_variant_read_splitter cvrs_port_props u_port_props (
    .clk            (clk),
    .rst_n          (rst_n),
    .op_valid       (op.valid),
    .op_ready       (op.ready),
    .op_last_op     (op.last_op),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .pre_length     (res.pre_length),
    .variant_length (res.variant_length),
    .post_start     (res.post_start),
    .post_present   (res.post_present),
    .site_aligned   (res.site_aligned)
);
